>>> rtl/core/chacha_pkg.sv
package chacha_pkg;

  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned NUM_WORDS         = 16;
  localparam int unsigned POS_W             = 6;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 64;

  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_words_t;

  typedef struct packed {
    logic [7:0] data_in;
    logic       first_of_message;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_PART_0   = 3'd0,
    CFG_KEY_PART_1   = 3'd1,
    CFG_KEY_PART_2   = 3'd2,
    CFG_KEY_PART_3   = 3'd3,
    CFG_INIT_COUNTER = 3'd4,
    CFG_NONCE_LOW    = 3'd5,
    CFG_NONCE_HIGH   = 3'd6
  } cfg_idx_t;

  function automatic word_t rotl(input word_t x, input int unsigned s);
    rotl = (x << s) | (x >> (WORD_W - s));
  endfunction

endpackage

>>> rtl/core/chacha_qr.sv
module chacha_qr (
  input  chacha_pkg::qr_words_t qr_in,
  output chacha_pkg::qr_words_t qr_out
);

  chacha_pkg::word_t a1, b1, c1, d1;
  chacha_pkg::word_t a2, b2, c2, d2;

  always_comb begin
    a1 = qr_in.a + qr_in.b;
    d1 = chacha_pkg::rotl(qr_in.d ^ a1, chacha_pkg::ROT_A);
    c1 = qr_in.c + d1;
    b1 = chacha_pkg::rotl(qr_in.b ^ c1, chacha_pkg::ROT_B);
    a2 = a1 + b1;
    d2 = chacha_pkg::rotl(d1 ^ a2, chacha_pkg::ROT_C);
    c2 = c1 + d2;
    b2 = chacha_pkg::rotl(b1 ^ c2, chacha_pkg::ROT_D);
    qr_out.a = a2;
    qr_out.b = b2;
    qr_out.c = c2;
    qr_out.d = d2;
  end

endmodule

>>> rtl/core/chacha20_stream_cipher.sv
// Bytes with a keystream block in hand: result registered straight from the input
// transfer when the output is free, one byte per cycle while the output is not stalled.
// A byte that needs a new block waits, with the input stalled, through load, one
// quarter-round per cycle on the shared quarter-round unit, feed-forward add, result.
// Synchronous active-low reset clears configuration, counters and the held-block flag;
// no keystream block is held after reset.
module chacha20_stream_cipher #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  chacha_pkg::in_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output chacha_pkg::out_t                    out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned DR_W = $clog2(DOUBLE_ROUNDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] key0_r, key0_nxt, key1_r, key1_nxt, key2_r, key2_nxt, key3_r, key3_nxt;
  logic [63:0] nonce_lo_r, nonce_lo_nxt;
  chacha_pkg::word_t init_ctr_r, init_ctr_nxt, nonce_hi_r, nonce_hi_nxt;
  chacha_pkg::word_t ctr_r, ctr_nxt;
  logic [chacha_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic blk_ready_r, blk_ready_nxt;
  logic [2:0] step_r, step_nxt;
  logic [DR_W-1:0] dr_r, dr_nxt;
  logic out_valid_r, out_valid_nxt;
  chacha_pkg::out_t out_data_r, out_data_nxt;
  logic [7:0] hold_data_r, hold_data_nxt;
  logic hold_last_r, hold_last_nxt;

  chacha_pkg::word_t work_r [chacha_pkg::NUM_WORDS];
  chacha_pkg::word_t work_nxt [chacha_pkg::NUM_WORDS];
  chacha_pkg::word_t init_w [chacha_pkg::NUM_WORDS];
  chacha_pkg::word_t round_w [chacha_pkg::NUM_WORDS];

  chacha_pkg::qr_words_t qr_in, qr_out;

  logic out_free;
  logic [1:0] rot_amt [4];
  chacha_pkg::word_t row_w [4];
  chacha_pkg::word_t ks_word;
  logic [7:0] ks_byte;

  chacha_qr u_qr (
    .qr_in  (qr_in),
    .qr_out (qr_out)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign ks_word = work_r[pos_r[5:2]];
  assign ks_byte = 8'(ks_word >> {pos_r[1:0], 3'b000});

  always_comb begin
    init_w[0]  = chacha_pkg::SIGMA_0;
    init_w[1]  = chacha_pkg::SIGMA_1;
    init_w[2]  = chacha_pkg::SIGMA_2;
    init_w[3]  = chacha_pkg::SIGMA_3;
    init_w[4]  = key0_r[31:0];
    init_w[5]  = key0_r[63:32];
    init_w[6]  = key1_r[31:0];
    init_w[7]  = key1_r[63:32];
    init_w[8]  = key2_r[31:0];
    init_w[9]  = key2_r[63:32];
    init_w[10] = key3_r[31:0];
    init_w[11] = key3_r[63:32];
    init_w[12] = ctr_r;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
  end

  // Column 0 feeds the quarter-round; rows then rotate so the next column or
  // diagonal lands in column 0. The last step of each half also (un)diagonalises.
  always_comb begin
    qr_in.a = work_r[0];
    qr_in.b = work_r[4];
    qr_in.c = work_r[8];
    qr_in.d = work_r[12];
    priority if (step_r == 3'd3) begin
      rot_amt[0] = 2'd1;
      rot_amt[1] = 2'd2;
      rot_amt[2] = 2'd3;
      rot_amt[3] = 2'd0;
    end else if (step_r == 3'd7) begin
      rot_amt[0] = 2'd1;
      rot_amt[1] = 2'd0;
      rot_amt[2] = 2'd3;
      rot_amt[3] = 2'd2;
    end else begin
      rot_amt[0] = 2'd1;
      rot_amt[1] = 2'd1;
      rot_amt[2] = 2'd1;
      rot_amt[3] = 2'd1;
    end
    row_w[0] = qr_out.a;
    row_w[1] = qr_out.b;
    row_w[2] = qr_out.c;
    row_w[3] = qr_out.d;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        logic [1:0] src;
        src = 2'(c) + rot_amt[r];
        if (src == 2'd0) begin
          round_w[4*r + c] = row_w[r];
        end else begin
          round_w[4*r + c] = work_r[4*r + 32'(src)];
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    key0_nxt      = key0_r;
    key1_nxt      = key1_r;
    key2_nxt      = key2_r;
    key3_nxt      = key3_r;
    init_ctr_nxt  = init_ctr_r;
    nonce_lo_nxt  = nonce_lo_r;
    nonce_hi_nxt  = nonce_hi_r;
    ctr_nxt       = ctr_r;
    pos_nxt       = pos_r;
    blk_ready_nxt = blk_ready_r;
    step_nxt      = step_r;
    dr_nxt        = dr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    hold_data_nxt = hold_data_r;
    hold_last_nxt = hold_last_r;
    for (int i = 0; i < chacha_pkg::NUM_WORDS; i++) begin
      work_nxt[i] = work_r[i];
    end

    if (cfg_valid && cfg_ready) begin
      unique case (chacha_pkg::cfg_idx_t'(cfg_index))
        chacha_pkg::CFG_KEY_PART_0:   key0_nxt = cfg_wdata;
        chacha_pkg::CFG_KEY_PART_1:   key1_nxt = cfg_wdata;
        chacha_pkg::CFG_KEY_PART_2:   key2_nxt = cfg_wdata;
        chacha_pkg::CFG_KEY_PART_3:   key3_nxt = cfg_wdata;
        chacha_pkg::CFG_INIT_COUNTER: init_ctr_nxt = cfg_wdata[31:0];
        chacha_pkg::CFG_NONCE_LOW:    nonce_lo_nxt = cfg_wdata;
        chacha_pkg::CFG_NONCE_HIGH:   nonce_hi_nxt = cfg_wdata[31:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          hold_data_nxt = in_data.data_in;
          hold_last_nxt = in_data.last_in;
          if (in_data.first_of_message) begin
            pos_nxt       = '0;
            ctr_nxt       = init_ctr_r;
            blk_ready_nxt = 1'b0;
            state_nxt     = ST_INIT;
          end else if (!blk_ready_r) begin
            state_nxt = ST_INIT;
          end else if (out_free) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.data_out  = in_data.data_in ^ ks_byte;
            out_data_nxt.last_out  = in_data.last_in;
            pos_nxt                = pos_r + 1'b1;
            if (pos_r == '1) begin
              blk_ready_nxt = 1'b0;
            end
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_INIT: begin
        for (int i = 0; i < chacha_pkg::NUM_WORDS; i++) begin
          work_nxt[i] = init_w[i];
        end
        step_nxt  = '0;
        dr_nxt    = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        for (int i = 0; i < chacha_pkg::NUM_WORDS; i++) begin
          work_nxt[i] = round_w[i];
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd7) begin
          dr_nxt = dr_r + 1'b1;
          if (dr_r == DR_W'(DOUBLE_ROUNDS - 1)) begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        for (int i = 0; i < chacha_pkg::NUM_WORDS; i++) begin
          work_nxt[i] = work_r[i] + init_w[i];
        end
        ctr_nxt       = ctr_r + 1'b1;
        blk_ready_nxt = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.data_out = hold_data_r ^ ks_byte;
          out_data_nxt.last_out = hold_last_r;
          pos_nxt               = pos_r + 1'b1;
          if (pos_r == '1) begin
            blk_ready_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key0_r      <= '0;
      key1_r      <= '0;
      key2_r      <= '0;
      key3_r      <= '0;
      init_ctr_r  <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      ctr_r       <= '0;
      pos_r       <= '0;
      blk_ready_r <= 1'b0;
      step_r      <= '0;
      dr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key0_r      <= key0_nxt;
      key1_r      <= key1_nxt;
      key2_r      <= key2_nxt;
      key3_r      <= key3_nxt;
      init_ctr_r  <= init_ctr_nxt;
      nonce_lo_r  <= nonce_lo_nxt;
      nonce_hi_r  <= nonce_hi_nxt;
      ctr_r       <= ctr_nxt;
      pos_r       <= pos_nxt;
      blk_ready_r <= blk_ready_nxt;
      step_r      <= step_nxt;
      dr_r        <= dr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    hold_data_r <= hold_data_nxt;
    hold_last_r <= hold_last_nxt;
    for (int i = 0; i < chacha_pkg::NUM_WORDS; i++) begin
      work_r[i] <= work_nxt[i];
    end
  end

endmodule

>>> tb/chacha_stream_checker.sv
`timescale 1ns / 1ps
module chacha_stream_checker #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  chacha_pkg::in_t                   in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  chacha_pkg::out_t                  out_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                mismatches,
  output int                                in_flight
);

  logic [chacha_pkg::CFG_DATA_W-1:0] key_reg [4];
  logic [chacha_pkg::CFG_DATA_W-1:0] nonce_lo_reg;
  chacha_pkg::word_t                 ctr_init_reg;
  chacha_pkg::word_t                 nonce_hi_reg;
  chacha_pkg::word_t                 stream_words [chacha_pkg::NUM_WORDS];
  logic [chacha_pkg::POS_W-1:0]      stream_pos;
  chacha_pkg::word_t                 next_counter;
  logic                              block_held;
  chacha_pkg::out_t                  expected_bytes [$];
  int                                errs = 0;

  function automatic chacha_pkg::word_t rol(chacha_pkg::word_t x, int unsigned s);
    return (x << s) | (x >> (chacha_pkg::WORD_W - s));
  endfunction

  function automatic chacha_pkg::qr_words_t quarter_mix(chacha_pkg::qr_words_t q);
    q.a += q.b; q.d = rol(q.d ^ q.a, chacha_pkg::ROT_A);
    q.c += q.d; q.b = rol(q.b ^ q.c, chacha_pkg::ROT_B);
    q.a += q.b; q.d = rol(q.d ^ q.a, chacha_pkg::ROT_C);
    q.c += q.d; q.b = rol(q.b ^ q.c, chacha_pkg::ROT_D);
    return q;
  endfunction

  always @(posedge clk) begin : track
    chacha_pkg::word_t start_words [chacha_pkg::NUM_WORDS];
    chacha_pkg::word_t mix [chacha_pkg::NUM_WORDS];
    chacha_pkg::out_t  want;
    logic [7:0]        pad;
    if (!rst_n) begin
      foreach (key_reg[k]) key_reg[k] = '0;
      nonce_lo_reg = '0;
      ctr_init_reg = '0;
      nonce_hi_reg = '0;
      stream_pos   = '0;
      next_counter = '0;
      block_held   = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (chacha_pkg::cfg_idx_t'(cfg_index))
          chacha_pkg::CFG_KEY_PART_0:   key_reg[0] = cfg_wdata;
          chacha_pkg::CFG_KEY_PART_1:   key_reg[1] = cfg_wdata;
          chacha_pkg::CFG_KEY_PART_2:   key_reg[2] = cfg_wdata;
          chacha_pkg::CFG_KEY_PART_3:   key_reg[3] = cfg_wdata;
          chacha_pkg::CFG_INIT_COUNTER: ctr_init_reg = cfg_wdata[chacha_pkg::WORD_W-1:0];
          chacha_pkg::CFG_NONCE_LOW:    nonce_lo_reg = cfg_wdata;
          chacha_pkg::CFG_NONCE_HIGH:   nonce_hi_reg = cfg_wdata[chacha_pkg::WORD_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("out transfer with no byte pending: data_out %02h, last_out %0b",
                 out_data.data_out, out_data.last_out);
          errs++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.data_out !== want.data_out) begin
            $error("data_out: expected %02h, got %02h", want.data_out, out_data.data_out);
            errs++;
          end
          if (out_data.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_data.last_out);
            errs++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (in_data.first_of_message) begin
          stream_pos   = '0;
          next_counter = ctr_init_reg;
          block_held   = 1'b0;
        end
        if (!block_held) begin
          start_words[0] = chacha_pkg::SIGMA_0;
          start_words[1] = chacha_pkg::SIGMA_1;
          start_words[2] = chacha_pkg::SIGMA_2;
          start_words[3] = chacha_pkg::SIGMA_3;
          for (int k = 0; k < 4; k++) begin
            start_words[4 + 2 * k] = key_reg[k][chacha_pkg::WORD_W-1:0];
            start_words[5 + 2 * k] =
              key_reg[k][chacha_pkg::CFG_DATA_W-1:chacha_pkg::WORD_W];
          end
          start_words[12] = next_counter;
          start_words[13] = nonce_lo_reg[chacha_pkg::WORD_W-1:0];
          start_words[14] = nonce_lo_reg[chacha_pkg::CFG_DATA_W-1:chacha_pkg::WORD_W];
          start_words[15] = nonce_hi_reg;
          mix = start_words;
          repeat (DOUBLE_ROUNDS) begin
            {mix[0], mix[4], mix[8], mix[12]}  = quarter_mix({mix[0], mix[4], mix[8], mix[12]});
            {mix[1], mix[5], mix[9], mix[13]}  = quarter_mix({mix[1], mix[5], mix[9], mix[13]});
            {mix[2], mix[6], mix[10], mix[14]} = quarter_mix({mix[2], mix[6], mix[10], mix[14]});
            {mix[3], mix[7], mix[11], mix[15]} = quarter_mix({mix[3], mix[7], mix[11], mix[15]});
            {mix[0], mix[5], mix[10], mix[15]} = quarter_mix({mix[0], mix[5], mix[10], mix[15]});
            {mix[1], mix[6], mix[11], mix[12]} = quarter_mix({mix[1], mix[6], mix[11], mix[12]});
            {mix[2], mix[7], mix[8], mix[13]}  = quarter_mix({mix[2], mix[7], mix[8], mix[13]});
            {mix[3], mix[4], mix[9], mix[14]}  = quarter_mix({mix[3], mix[4], mix[9], mix[14]});
          end
          foreach (stream_words[k]) stream_words[k] = start_words[k] + mix[k];
          next_counter++;
          block_held = 1'b1;
        end
        pad = stream_words[stream_pos[chacha_pkg::POS_W-1:2]][8 * stream_pos[1:0] +: 8];
        want.data_out = in_data.data_in ^ pad;
        want.last_out = in_data.last_in;
        expected_bytes.push_back(want);
        stream_pos++;
        if (stream_pos == '0) block_held = 1'b0;
      end
    end
    in_flight  <= expected_bytes.size();
    mismatches <= errs;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned SETTLE_CYCLES  = 8 * chacha_pkg::DOUBLE_ROUNDS_DEF + 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_BYTES    = 188;
  localparam int unsigned NUM_PHASES     = 6;

  typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  chacha_pkg::in_t                   in_data;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  chacha_pkg::out_t                  out_data;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int stall_pct    = 0;
  int idle_pct     = 0;
  int quiet_cycles = 0;
  int mismatches;
  int in_flight;

  chacha20_stream_cipher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  chacha_stream_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(chacha_pkg::cfg_idx_t idx,
                           logic [chacha_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(fill_t fill, bit every);
    chacha_pkg::cfg_idx_t              r;
    logic [chacha_pkg::CFG_DATA_W-1:0] v;
    r = r.first();
    repeat (r.num()) begin
      case (fill)
        FILL_ZERO: v = '0;
        FILL_ONES: v = '1;
        default:   v = {$urandom, $urandom};
      endcase
      if (every || $urandom_range(1)) write_reg(r, v);
      r = r.next();
    end
  endtask

  task automatic send_byte(logic [7:0] d, bit first, bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_in: d, first_of_message: first, last_in: last};
    do @(posedge clk); while (in_stall);
  endtask

  // wait for every byte to come back, then let any block computation finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int len;
    int left;
    bit start;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no message start after reset: counter zero, all-zero key
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h5a, 1'b0, 1'b0);
    drain();

    write_reg(chacha_pkg::CFG_KEY_PART_0, 64'h0706_0504_0302_0100);
    write_reg(chacha_pkg::CFG_KEY_PART_1, 64'h0f0e_0d0c_0b0a_0908);
    write_reg(chacha_pkg::CFG_KEY_PART_2, 64'h1716_1514_1312_1110);
    write_reg(chacha_pkg::CFG_KEY_PART_3, 64'h1f1e_1d1c_1b1a_1918);
    write_reg(chacha_pkg::CFG_INIT_COUNTER, 64'h1);
    write_reg(chacha_pkg::CFG_NONCE_LOW, 64'h4a00_0000_0900_0000);
    write_reg(chacha_pkg::CFG_NONCE_HIGH, 64'h0);

    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h7f, 1'b0, 1'b0);
    send_byte(8'hfe, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'haa, 1'b0, 1'b0);
    send_byte(8'h0f, 1'b0, 1'b0);
    send_byte(8'hf0, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'hc3, 1'b0, 1'b0);
    send_byte(8'h3c, 1'b0, 1'b0);
    send_byte(8'h96, 1'b0, 1'b0);
    send_byte(8'h69, 1'b0, 1'b1);
    send_byte(8'ha5, 1'b1, 1'b1);
    send_byte(8'h3c, 1'b0, 1'b0);
    send_byte(8'hc3, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      idle_pct = (phase < 2) ? 25 : (phase < 4) ? 71 : 0;
      stall_pct <= (phase < 2) ? 71 : (phase < 4) ? 25 : 0;
      case (phase)
        0: program_regs(FILL_ONES, 1'b1);
        2: program_regs(FILL_ZERO, 1'b1);
        3: begin
          program_regs(FILL_RANDOM, 1'b0);
          write_reg(chacha_pkg::CFG_INIT_COUNTER, 64'hffff_fffe);
        end
        default: program_regs(FILL_RANDOM, phase == 1);
      endcase
      left = PHASE_BYTES;
      for (int m = 0; left > 0; m++) begin
        len = (m == 0 || $urandom_range(9) == 0) ? $urandom_range(130, 200)
                                                  : $urandom_range(1, 90);
        if (len > left) len = left;
        // a phase may carry on with the block held from before the register writes
        start = (m == 0) ? (phase == 0 || phase == 3 || $urandom_range(1) == 1)
                         : ($urandom_range(9) != 0);
        for (int j = 0; j < len; j++) begin
          send_byte(8'($urandom),
                    (j == 0) ? start : ($urandom_range(49) == 0),
                    (j == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0));
        end
        left -= len;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
